FILE: src/ring_buffer_deque_core_assert.svh
// Assertion macros shared by the deque RTL.
`ifndef RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`define RING_BUFFER_DEQUE_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define RBD_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rbd_pkg.sv
// Package for the ring buffer deque: request and status codes, defaults.
package rbd_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_W          = 11;
    localparam int CNT_OUT_W      = 11;
    localparam int REQ_W          = 3;
    localparam int STATUS_W       = 2;
    localparam int ITEM_W         = 32;
    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_FRONT = 3'd4,
        REQ_READ_BACK  = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

FILE: src/rbd_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ring_buffer_deque_core.sv
// Top level of the ring buffer deque: index control around one slot RAM.
//
// Usage:
//   Requests enter on i_req_type / i_item_value and are taken at a clock edge
//   with i_start high and o_busy low. o_busy stays low: a request can be
//   issued every cycle.
//   Exactly one result beat follows each request, on the cycle after it is
//   taken, marked by o_done for one cycle. The result carries read data,
//   status, element count and the empty/full flags after the request.
//   Throughput is 1 request per cycle. The slot RAM has a registered read;
//   each request touches one slot, and a write always lands at an edge
//   before any later read of that slot is issued.
//   The receiver cannot stall; a result beat is gone after its cycle.
//   Capacity is set via i_cfg_we / i_cfg_wdata; users must write it while no
//   request is in flight (not enforced); 0 acts as 1, above DEPTH as DEPTH.
//   Reset empties the deque, zeroes both indices and sets capacity to 1024.
//   Slot contents are not cleared; there is no clearing pass.
`include "ring_buffer_deque_core_assert.svh"

module ring_buffer_deque_core #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [rbd_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [rbd_pkg::ITEM_W-1:0]   i_item_value,
    input  logic                                i_cfg_we,
    input  logic [rbd_pkg::CFG_W-1:0]           i_cfg_wdata,
    output logic                                o_done,
    output logic signed [rbd_pkg::ITEM_W-1:0]   o_read_value,
    output logic [rbd_pkg::STATUS_W-1:0]        o_status,
    output logic [rbd_pkg::CNT_OUT_W-1:0]       o_element_count,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    import rbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

    logic [CFG_W-1:0]      r_cap_cfg;
    logic [AW-1:0]         r_front, n_front;
    logic [AW-1:0]         r_back, n_back;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_done;
    t_status               r_status, n_status;
    logic                  r_rd_hit, n_rd_hit;
    logic                  r_rd_neg, n_rd_neg;

    logic [KW-1:0]         cap_k;
    logic [CW-1:0]         cap;
    logic                  w_accept;
    logic                  is_empty_now;
    logic                  is_full_now;
    logic [CW-1:0]         front_ext, back_ext;
    logic [AW-1:0]         front_up, front_dn, back_up, back_dn;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [ITEM_W-1:0]     slot_word;

    assign o_busy   = 1'b0;
    assign w_accept = i_rst_n && i_start && !o_busy;

    // Clamp the capacity register into 1..DEPTH.
    always_comb begin
        cap_k = KW'(r_cap_cfg);
        if (cap_k == '0) begin
            cap_k = KW'(1);
        end else if (cap_k > DEPTH_K) begin
            cap_k = DEPTH_K;
        end
    end
    assign cap = CW'(cap_k);

    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count >= cap);

    assign front_ext = CW'(r_front);
    assign back_ext  = CW'(r_back);

    // Wrap at capacity; an index left above capacity wraps too.
    assign front_up = (front_ext + 1'b1 >= cap) ? '0 : AW'(front_ext + 1'b1);
    assign back_up  = (back_ext + 1'b1 >= cap) ? '0 : AW'(back_ext + 1'b1);
    assign front_dn = (r_front == '0 || front_ext > cap) ? AW'(cap - 1'b1)
                                                         : r_front - 1'b1;
    assign back_dn  = (r_back == '0 || back_ext > cap) ? AW'(cap - 1'b1)
                                                       : r_back - 1'b1;

    assign ram_wdata = DATA_WIDTH'($unsigned(i_item_value));

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_status  = ST_DONE;
        n_rd_hit  = 1'b0;
        n_rd_neg  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_front;
        ram_re    = 1'b0;
        ram_raddr = r_front;
        if (w_accept) begin
            unique case (i_req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (is_full_now) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        if (is_empty_now) begin
                            n_front   = '0;
                            n_back    = '0;
                            ram_waddr = '0;
                        end else if (i_req_type == REQ_PUSH_FRONT) begin
                            n_front   = front_dn;
                            ram_waddr = front_dn;
                        end else begin
                            n_back    = back_up;
                            ram_waddr = back_up;
                        end
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK: begin
                    if (is_empty_now) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (i_req_type == REQ_POP_FRONT) begin
                            n_front = front_up;
                        end else begin
                            n_back = back_dn;
                        end
                    end
                end
                REQ_READ_FRONT, REQ_READ_BACK: begin
                    if (is_empty_now) begin
                        n_status = ST_EMPTY;
                        n_rd_neg = 1'b1;
                    end else begin
                        n_rd_hit  = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = (i_req_type == REQ_READ_FRONT) ? r_front : r_back;
                    end
                end
                default: begin
                    // unknown request: no state change, plain done beat
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= CAP_RESET;
            r_front   <= '0;
            r_back    <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_status  <= ST_DONE;
            r_rd_hit  <= 1'b0;
            r_rd_neg  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_wdata;
            end
            r_front  <= n_front;
            r_back   <= n_back;
            r_count  <= n_count;
            r_done   <= w_accept;
            r_status <= n_status;
            r_rd_hit <= n_rd_hit;
            r_rd_neg <= n_rd_neg;
        end
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Narrow slots read back sign-extended; wide ones give their low word.
    generate
        if (DATA_WIDTH >= ITEM_W) begin : g_wide
            assign slot_word = ram_rdata[ITEM_W-1:0];
        end else begin : g_narrow
            assign slot_word = ITEM_W'($signed(ram_rdata));
        end
    endgenerate

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_value    = r_rd_hit ? $signed(slot_word)
                           : (r_rd_neg ? -32'sd1 : '0);
    assign o_element_count = CNT_OUT_W'(r_count);
    assign o_is_empty      = is_empty_now;
    assign o_is_full       = is_full_now;

    `RBD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `RBD_ASSERT(a_done_follows, i_clk, i_rst_n, o_done == $past(w_accept), "result beat lost or extra")
    `RBD_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, w_accept && !is_full_now && (i_req_type == REQ_PUSH_FRONT || i_req_type == REQ_PUSH_BACK), r_count == $past(r_count) + 1'b1, "push did not grow count")
    `RBD_ASSERT_NEXT(a_pop_empty_hold, i_clk, i_rst_n, w_accept && is_empty_now && (i_req_type == REQ_POP_FRONT || i_req_type == REQ_POP_BACK), $stable(r_front) && $stable(r_back) && $stable(r_count), "rejected pop moved state")

endmodule
